[design/ipdbf_pkg.sv]
// ----------------------------------------------------------------------------
// ipdbf_pkg
// Shared types and constants for the IPv4 destination block filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdbf_pkg;

  // Request commands.
  typedef enum logic [2:0] {
    CMD_FRAME    = 3'd0,
    CMD_SET_ADDR = 3'd1,
    CMD_DEL_ADDR = 3'd2,
    CMD_SET_PAIR = 3'd3,
    CMD_DEL_PAIR = 3'd4
  } cmd_e;

  // Verdict causes.
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_ADDR_HIT  = 3'd1;
  localparam logic [2:0] CAUSE_PAIR_HIT  = 3'd2;
  localparam logic [2:0] CAUSE_NOT_IPV4  = 3'd3;
  localparam logic [2:0] CAUSE_TRUNCATED = 3'd4;
  localparam logic [2:0] CAUSE_OTHER     = 3'd5;

  // Table command status codes.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Result kinds.
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Byte positions of captured header fields.
  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_DADDR_0  = 6'd30;
  localparam logic [5:0] POS_DADDR_1  = 6'd31;
  localparam logic [5:0] POS_DADDR_2  = 6'd32;
  localparam logic [5:0] POS_DADDR_3  = 6'd33;
  localparam logic [5:0] POS_DPORT_HI = 6'd36;
  localparam logic [5:0] POS_DPORT_LO = 6'd37;
  localparam logic [5:0] POS_MAX      = 6'd63;

  // Minimum frame lengths.
  localparam logic [6:0] LEN_ETH_MIN = 7'd14;
  localparam logic [6:0] LEN_IP_MIN  = 7'd34;
  localparam logic [6:0] LEN_TCP_MIN = 7'd54;
  localparam logic [6:0] LEN_UDP_MIN = 7'd42;

  // Header fields of a frame, including its final byte.
  typedef struct packed {
    logic [6:0]  frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
  } frame_info_t;

endpackage

`default_nettype wire

[design/ipdbf_ram.sv]
// ----------------------------------------------------------------------------
// ipdbf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdbf_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/ipdbf_parser.sv]
// ----------------------------------------------------------------------------
// ipdbf_parser
// Counts frame bytes and captures the header fields used by the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdbf_parser import ipdbf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  output frame_info_t      info_o
);

  logic [5:0]  pos_q, pos_d;
  logic [15:0] ether_q, ether_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;

  // Field capture at the current byte position.
  always_comb begin
    ether_d = ether_q;
    proto_d = proto_q;
    addr_d  = addr_q;
    port_d  = port_q;
    case (pos_q)
      POS_ETYPE_HI: ether_d = {frame_byte_i, ether_q[7:0]};
      POS_ETYPE_LO: ether_d = {ether_q[15:8], frame_byte_i};
      POS_PROTO:    proto_d = frame_byte_i;
      POS_DADDR_0, POS_DADDR_1, POS_DADDR_2, POS_DADDR_3:
                    addr_d  = {addr_q[23:0], frame_byte_i};
      POS_DPORT_HI: port_d  = {frame_byte_i, port_q[7:0]};
      POS_DPORT_LO: port_d  = {port_q[15:8], frame_byte_i};
      default: ;
    endcase
    if (frame_last_i) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 6'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  // The view of the frame including the byte presented now.
  assign info_o.frame_len    = {1'b0, pos_q} + 7'd1;
  assign info_o.ether_type   = ether_d;
  assign info_o.ip_protocol  = proto_d;
  assign info_o.dest_address = addr_d;
  assign info_o.dest_port    = port_d;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ether_q <= '0;
      proto_q <= '0;
      addr_q  <= '0;
      port_q  <= '0;
    end else if (byte_en_i) begin
      pos_q   <= pos_d;
      ether_q <= ether_d;
      proto_q <= proto_d;
      addr_q  <= addr_d;
      port_q  <= port_d;
    end
  end

endmodule

`default_nettype wire

[design/ipv4_dest_block_filter.sv]
// A frame byte that is not last leaves the block idle, so such bytes are taken back to back.
// A final byte passes S_JUDGE, and goes straight to S_FIN when no table is needed, else
// through an address scan (S_ASCAN, S_AEND) and, for TCP or UDP, a pair scan (S_PSCAN, S_PEND).
// Address requests scan the address table and pair requests the pair table, then write in
// S_AEND or S_PEND; a scan reads one entry per cycle. A stalled result holds input.
// After reset the tables are cleared in S_CLEAR, with in_stall_o high.
// ----------------------------------------------------------------------------
// ipv4_dest_block_filter
// Per-frame pass/drop filter against address and address/port block tables.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dest_block_filter import ipdbf_pkg::*; #(
  parameter int ADDRESS_TABLE_DEPTH = 1024,
  parameter int PAIR_TABLE_DEPTH    = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  input  wire logic [31:0] rule_address_i,
  input  wire logic [15:0] rule_port_i,
  input  wire logic [31:0] rule_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic             drop_o,
  output logic [2:0]       verdict_cause_o,
  output logic [1:0]       table_status_o
);

  localparam int AW = $clog2(ADDRESS_TABLE_DEPTH);
  localparam int PW = $clog2(PAIR_TABLE_DEPTH);
  localparam int MAXD = (ADDRESS_TABLE_DEPTH > PAIR_TABLE_DEPTH) ?
                        ADDRESS_TABLE_DEPTH : PAIR_TABLE_DEPTH;
  localparam int SW = $clog2(MAXD);
  localparam logic [SW-1:0] ALAST = SW'(ADDRESS_TABLE_DEPTH - 1);
  localparam logic [SW-1:0] PLAST = SW'(PAIR_TABLE_DEPTH - 1);
  localparam logic [SW-1:0] MLAST = SW'(MAXD - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_JUDGE, S_ASCAN, S_AEND, S_PSCAN, S_PEND, S_FIN
  } state_e;

  state_e      state_q, state_d;
  logic [SW-1:0] idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic        issued_q, issued_d, rd_v_q, rd_v_d;
  logic        hit_q, hit_d, hit_blk_q, hit_blk_d, free_q, free_d;
  logic [SW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  cmd_e        cmd_q, cmd_d;
  logic [6:0]  len_q, len_d;
  logic [15:0] ether_q, ether_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] key_addr_q, key_addr_d;
  logic [15:0] key_port_q, key_port_d;
  logic        blk_q, blk_d;
  logic        res_kind_q, res_kind_d, res_drop_q, res_drop_d;
  logic [2:0]  res_cause_q, res_cause_d;
  logic [1:0]  res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d, out_kind_q, out_kind_d, out_drop_q, out_drop_d;
  logic [2:0]  out_cause_q, out_cause_d;
  logic [1:0]  out_status_q, out_status_d;

  logic        accept, byte_en;
  frame_info_t info;
  logic        a_we, p_we;
  logic [AW-1:0] a_waddr;
  logic [PW-1:0] p_waddr;
  logic [33:0] a_wdata, a_rdata;
  logic [49:0] p_wdata, p_rdata;
  logic [SW-1:0] scan_last;
  logic        ent_valid, ent_match, ent_blk;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign byte_en    = accept && (cmd_i == CMD_FRAME);

  ipdbf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (byte_en),
    .frame_byte_i (frame_byte_i),
    .frame_last_i (frame_last_i),
    .info_o       (info)
  );

  // Address table entry: {valid, block, address}.
  ipdbf_ram #(.WIDTH(34), .DEPTH(ADDRESS_TABLE_DEPTH)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (a_rdata)
  );

  // Pair table entry: {valid, block, address, port}.
  ipdbf_ram #(.WIDTH(50), .DEPTH(PAIR_TABLE_DEPTH)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (idx_q[PW-1:0]),
    .rdata_o (p_rdata)
  );

  // Decode of the entry read back during a scan.
  always_comb begin
    if (state_q == S_ASCAN) begin
      scan_last = ALAST;
      ent_valid = a_rdata[33];
      ent_blk   = a_rdata[32];
      ent_match = a_rdata[33] && (a_rdata[31:0] == key_addr_q);
    end else begin
      scan_last = PLAST;
      ent_valid = p_rdata[49];
      ent_blk   = p_rdata[48];
      ent_match = p_rdata[49] && (p_rdata[47:16] == key_addr_q) &&
                  (p_rdata[15:0] == key_port_q);
    end
  end

  // Sequencer: table clearing, scans, read-modify-write and results.
  always_comb begin
    state_d = state_q;   idx_d = idx_q;       chk_idx_d = chk_idx_q;
    issued_d = issued_q; rd_v_d = rd_v_q;     hit_d = hit_q;
    hit_blk_d = hit_blk_q; free_d = free_q;   hit_idx_d = hit_idx_q;
    free_idx_d = free_idx_q; cmd_d = cmd_q;   len_d = len_q;
    ether_d = ether_q;   proto_d = proto_q;   key_addr_d = key_addr_q;
    key_port_d = key_port_q; blk_d = blk_q;
    res_kind_d = res_kind_q; res_drop_d = res_drop_q;
    res_cause_d = res_cause_q; res_status_d = res_status_q;
    out_valid_d = out_valid_q; out_kind_d = out_kind_q; out_drop_d = out_drop_q;
    out_cause_d = out_cause_q; out_status_d = out_status_q;
    a_we = 1'b0; p_we = 1'b0;
    a_waddr = idx_q[AW-1:0]; p_waddr = idx_q[PW-1:0];
    a_wdata = '0; p_wdata = '0;

    // Output register drains independently of the sequencer.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        a_we  = (idx_q <= ALAST);
        p_we  = (idx_q <= PLAST);
        idx_d = idx_q + 1'b1;
        if (idx_q == MLAST) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_d      = cmd_e'(cmd_i);
          key_addr_d = rule_address_i;
          key_port_d = rule_port_i;
          blk_d      = (rule_value_i == 32'd1);
          idx_d = '0; issued_d = 1'b0; rd_v_d = 1'b0; hit_d = 1'b0; free_d = 1'b0;
          res_kind_d = KIND_STATUS; res_drop_d = 1'b0;
          res_cause_d = CAUSE_NONE; res_status_d = STATUS_DONE;
          case (cmd_e'(cmd_i))
            CMD_FRAME: begin
              len_d      = info.frame_len;
              ether_d    = info.ether_type;
              proto_d    = info.ip_protocol;
              key_addr_d = info.dest_address;
              key_port_d = info.dest_port;
              res_kind_d = KIND_VERDICT;
              if (frame_last_i) begin
                state_d = S_JUDGE;
              end
            end
            CMD_SET_ADDR, CMD_DEL_ADDR: state_d = S_ASCAN;
            CMD_SET_PAIR, CMD_DEL_PAIR: state_d = S_PSCAN;
            default: ;
          endcase
        end
      end

      // Checks that need no table.
      S_JUDGE: begin
        state_d = S_FIN;
        if (len_q < LEN_ETH_MIN) begin
          res_cause_d = CAUSE_TRUNCATED;
        end else if (ether_q != ETHERTYPE_IPV4) begin
          res_cause_d = CAUSE_NOT_IPV4;
        end else if (len_q < LEN_IP_MIN) begin
          res_cause_d = CAUSE_TRUNCATED;
        end else begin
          state_d = S_ASCAN;
        end
      end

      // One read issued and one entry checked per cycle.
      S_ASCAN, S_PSCAN: begin
        rd_v_d = !issued_q;
        if (!issued_q) begin
          chk_idx_d = idx_q;
          if (idx_q == scan_last) begin
            issued_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (rd_v_q) begin
          if (ent_match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            hit_blk_d = ent_blk;
          end
          if (!ent_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (chk_idx_q == scan_last) begin
            state_d = (state_q == S_ASCAN) ? S_AEND : S_PEND;
          end
        end
      end

      S_AEND: begin
        state_d = S_FIN;
        a_wdata = {1'b1, blk_q, key_addr_q};
        case (cmd_q)
          CMD_SET_ADDR: begin
            if (hit_q) begin
              a_we = 1'b1; a_waddr = hit_idx_q[AW-1:0];
            end else if (free_q) begin
              a_we = 1'b1; a_waddr = free_idx_q[AW-1:0];
            end else begin
              res_status_d = STATUS_FULL;
            end
          end
          CMD_DEL_ADDR: begin
            if (hit_q) begin
              a_we = 1'b1; a_waddr = hit_idx_q[AW-1:0]; a_wdata = '0;
            end else begin
              res_status_d = STATUS_NOT_FOUND;
            end
          end
          default: begin
            if (hit_q && hit_blk_q) begin
              res_drop_d  = 1'b1;
              res_cause_d = CAUSE_ADDR_HIT;
            end else if ((proto_q == PROTO_TCP && len_q < LEN_TCP_MIN) ||
                         (proto_q == PROTO_UDP && len_q < LEN_UDP_MIN)) begin
              res_cause_d = CAUSE_TRUNCATED;
            end else if (proto_q == PROTO_TCP || proto_q == PROTO_UDP) begin
              idx_d = '0; issued_d = 1'b0; rd_v_d = 1'b0;
              hit_d = 1'b0; free_d = 1'b0;
              state_d = S_PSCAN;
            end else begin
              res_cause_d = CAUSE_OTHER;
            end
          end
        endcase
      end

      S_PEND: begin
        state_d = S_FIN;
        p_wdata = {1'b1, blk_q, key_addr_q, key_port_q};
        case (cmd_q)
          CMD_SET_PAIR: begin
            if (hit_q) begin
              p_we = 1'b1; p_waddr = hit_idx_q[PW-1:0];
            end else if (free_q) begin
              p_we = 1'b1; p_waddr = free_idx_q[PW-1:0];
            end else begin
              res_status_d = STATUS_FULL;
            end
          end
          CMD_DEL_PAIR: begin
            if (hit_q) begin
              p_we = 1'b1; p_waddr = hit_idx_q[PW-1:0]; p_wdata = '0;
            end else begin
              res_status_d = STATUS_NOT_FOUND;
            end
          end
          default: begin
            if (hit_q && hit_blk_q) begin
              res_drop_d  = 1'b1;
              res_cause_d = CAUSE_PAIR_HIT;
            end
          end
        endcase
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_kind_d   = res_kind_q;
          out_drop_d   = res_drop_q;
          out_cause_d  = res_cause_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;   idx_q <= '0;      chk_idx_q <= '0;
      issued_q <= 1'b0;     rd_v_q <= 1'b0;   hit_q <= 1'b0;
      hit_blk_q <= 1'b0;    free_q <= 1'b0;   hit_idx_q <= '0;
      free_idx_q <= '0;     cmd_q <= CMD_FRAME; len_q <= '0;
      ether_q <= '0;        proto_q <= '0;    key_addr_q <= '0;
      key_port_q <= '0;     blk_q <= 1'b0;
      res_kind_q <= 1'b0;   res_drop_q <= 1'b0;
      res_cause_q <= '0;    res_status_q <= '0;
      out_valid_q <= 1'b0;  out_kind_q <= 1'b0; out_drop_q <= 1'b0;
      out_cause_q <= '0;    out_status_q <= '0;
    end else begin
      state_q <= state_d;   idx_q <= idx_d;   chk_idx_q <= chk_idx_d;
      issued_q <= issued_d; rd_v_q <= rd_v_d; hit_q <= hit_d;
      hit_blk_q <= hit_blk_d; free_q <= free_d; hit_idx_q <= hit_idx_d;
      free_idx_q <= free_idx_d; cmd_q <= cmd_d; len_q <= len_d;
      ether_q <= ether_d;   proto_q <= proto_d; key_addr_q <= key_addr_d;
      key_port_q <= key_port_d; blk_q <= blk_d;
      res_kind_q <= res_kind_d; res_drop_q <= res_drop_d;
      res_cause_q <= res_cause_d; res_status_q <= res_status_d;
      out_valid_q <= out_valid_d; out_kind_q <= out_kind_d; out_drop_q <= out_drop_d;
      out_cause_q <= out_cause_d; out_status_q <= out_status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign drop_o          = out_drop_q;
  assign verdict_cause_o = out_cause_q;
  assign table_status_o  = out_status_q;

  // A frame verdict never carries a table status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_VERDICT) |-> table_status_o == STATUS_DONE)
    else $error("verdict carries a table status");

  // A table status never carries a drop or a cause.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_STATUS) |-> !drop_o && verdict_cause_o == CAUSE_NONE)
    else $error("status carries verdict fields");

  // A drop is only caused by a table hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_o |->
      (verdict_cause_o == CAUSE_ADDR_HIT || verdict_cause_o == CAUSE_PAIR_HIT))
    else $error("drop without a table hit");

  // Tables are never written while a scan reads them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN || state_q == S_PSCAN) |-> !a_we && !p_we)
    else $error("table write during scan");

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives frame bytes and table requests into the IPv4 destination block filter.
// A built-in predictor keeps its own copy of the rule tables and header
// capture. Every verdict and status is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ipdbf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Small tables keep scans short and make the table-full case reachable.
  localparam int ADDR_DEPTH = 16;
  localparam int PAIR_DEPTH = 16;
  localparam int N_REQUESTS = 600;
  localparam int MIN_RESULTS = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  fbyte;
    logic        last;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic       kind;
    logic       drop;
    logic [2:0] cause;
    logic [1:0] status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] cmd_i = 3'd0;
  logic [7:0] frame_byte_i = 8'd0;
  logic frame_last_i = 1'b0;
  logic [31:0] rule_address_i = 32'd0;
  logic [15:0] rule_port_i = 16'd0;
  logic [31:0] rule_value_i = 32'd0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic result_kind_o;
  logic drop_o;
  logic [2:0] verdict_cause_o;
  logic [1:0] table_status_o;

  request_t request_q[$];
  outcome_t outcome_q[$];
  int errors = 0;
  int accepted = 0;
  int idle_cycles = 0;
  bit hold_start = 1'b0;
  int planned_results = 0;

  // Predictor state.
  logic [5:0]  cap_pos = '0;
  logic [15:0] cap_etype = '0;
  logic [7:0]  cap_proto = '0;
  logic [31:0] cap_daddr = '0;
  logic [15:0] cap_dport = '0;
  bit          addr_used[ADDR_DEPTH];
  logic [31:0] addr_key[ADDR_DEPTH];
  bit          addr_blk[ADDR_DEPTH];
  bit          pair_used[PAIR_DEPTH];
  logic [31:0] pair_key_a[PAIR_DEPTH];
  logic [15:0] pair_key_p[PAIR_DEPTH];
  bit          pair_blk[PAIR_DEPTH];

  logic [31:0] addr_pool[12];
  logic [15:0] port_pool[4];

  ipv4_dest_block_filter #(
    .ADDRESS_TABLE_DEPTH(ADDR_DEPTH),
    .PAIR_TABLE_DEPTH(PAIR_DEPTH)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .frame_byte_i(frame_byte_i), .frame_last_i(frame_last_i),
    .rule_address_i(rule_address_i), .rule_port_i(rule_port_i),
    .rule_value_i(rule_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .result_kind_o(result_kind_o), .drop_o(drop_o),
    .verdict_cause_o(verdict_cause_o), .table_status_o(table_status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int find_addr(logic [31:0] a);
    for (int i = 0; i < ADDR_DEPTH; i++)
      if (addr_used[i] && addr_key[i] == a) return i;
    return -1;
  endfunction

  function automatic int find_pair(logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < PAIR_DEPTH; i++)
      if (pair_used[i] && pair_key_a[i] == a && pair_key_p[i] == p) return i;
    return -1;
  endfunction

  // Verdict for a frame of length len from the captured header fields.
  function automatic outcome_t judge_frame(int len);
    outcome_t o;
    int h;
    o = '{KIND_VERDICT, 1'b0, CAUSE_NONE, STATUS_DONE};
    h = find_addr(cap_daddr);
    if (len < LEN_ETH_MIN) o.cause = CAUSE_TRUNCATED;
    else if (cap_etype != ETHERTYPE_IPV4) o.cause = CAUSE_NOT_IPV4;
    else if (len < LEN_IP_MIN) o.cause = CAUSE_TRUNCATED;
    else if (h >= 0 && addr_blk[h]) begin
      o.drop = 1'b1;
      o.cause = CAUSE_ADDR_HIT;
    end else if (cap_proto != PROTO_TCP && cap_proto != PROTO_UDP) o.cause = CAUSE_OTHER;
    else if ((cap_proto == PROTO_TCP && len < LEN_TCP_MIN) ||
             (cap_proto == PROTO_UDP && len < LEN_UDP_MIN)) o.cause = CAUSE_TRUNCATED;
    else begin
      h = find_pair(cap_daddr, cap_dport);
      if (h >= 0 && pair_blk[h]) begin
        o.drop = 1'b1;
        o.cause = CAUSE_PAIR_HIT;
      end
    end
    return o;
  endfunction

  // Applies one accepted request to the predictor and queues its outcome, if it yields one.
  task automatic filter_step(request_t r);
    outcome_t o;
    int h;
    bit blk;
    blk = (r.value == 32'd1);
    o = '{KIND_STATUS, 1'b0, CAUSE_NONE, STATUS_DONE};
    case (r.cmd)
      CMD_FRAME: begin
        case (cap_pos)
          POS_ETYPE_HI: cap_etype[15:8] = r.fbyte;
          POS_ETYPE_LO: cap_etype[7:0] = r.fbyte;
          POS_PROTO: cap_proto = r.fbyte;
          POS_DADDR_0, POS_DADDR_1, POS_DADDR_2, POS_DADDR_3:
            cap_daddr = {cap_daddr[23:0], r.fbyte};
          POS_DPORT_HI: cap_dport[15:8] = r.fbyte;
          POS_DPORT_LO: cap_dport[7:0] = r.fbyte;
          default: ;
        endcase
        if (!r.last) begin
          if (cap_pos != POS_MAX) cap_pos++;
          return;
        end
        o = judge_frame(int'(cap_pos) + 1);
        cap_pos = '0;
      end
      CMD_SET_ADDR: begin
        h = find_addr(r.addr);
        if (h < 0) begin
          o.status = STATUS_FULL;
          for (int i = 0; i < ADDR_DEPTH; i++)
            if (!addr_used[i]) begin
              addr_used[i] = 1'b1;
              addr_key[i] = r.addr;
              h = i;
              o.status = STATUS_DONE;
              break;
            end
        end
        if (h >= 0) addr_blk[h] = blk;
      end
      CMD_DEL_ADDR: begin
        h = find_addr(r.addr);
        if (h >= 0) addr_used[h] = 1'b0;
        else o.status = STATUS_NOT_FOUND;
      end
      CMD_SET_PAIR: begin
        h = find_pair(r.addr, r.port);
        if (h < 0) begin
          o.status = STATUS_FULL;
          for (int i = 0; i < PAIR_DEPTH; i++)
            if (!pair_used[i]) begin
              pair_used[i] = 1'b1;
              pair_key_a[i] = r.addr;
              pair_key_p[i] = r.port;
              h = i;
              o.status = STATUS_DONE;
              break;
            end
        end
        if (h >= 0) pair_blk[h] = blk;
      end
      CMD_DEL_PAIR: begin
        h = find_pair(r.addr, r.port);
        if (h >= 0) pair_used[h] = 1'b0;
        else o.status = STATUS_NOT_FOUND;
      end
      default: return;
    endcase
    outcome_q.push_back(o);
  endtask

  function automatic request_t rand_request(logic [2:0] cmd);
    request_t r;
    r.cmd = cmd;
    r.fbyte = 8'($urandom);
    r.last = 1'($urandom);
    r.addr = ($urandom_range(0, 7) == 0) ? $urandom : addr_pool[$urandom_range(0, 11)];
    r.port = ($urandom_range(0, 7) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
    r.value = ($urandom_range(0, 2) != 0) ? 32'd1 : $urandom;
    return r;
  endfunction

  task automatic add_rule(logic [2:0] cmd, logic [31:0] a, logic [15:0] p, logic [31:0] v);
    request_t r;
    r = rand_request(cmd);
    r.addr = a;
    r.port = p;
    r.value = v;
    request_q.push_back(r);
    planned_results++;
  endtask

  // A random table request, or now and then an unused command.
  task automatic add_random_rule();
    request_t r;
    if ($urandom_range(0, 15) == 0) begin
      request_q.push_back(rand_request(3'(CMD_DEL_PAIR) + 3'($urandom_range(1, 3))));
    end else begin
      r = rand_request(3'($urandom_range(CMD_SET_ADDR, CMD_DEL_PAIR)));
      request_q.push_back(r);
      planned_results++;
    end
  endtask

  // Queues a frame of len bytes; with mix set, random requests are sometimes slipped in.
  task automatic add_frame(int len, logic [15:0] etype, logic [7:0] proto,
                           logic [31:0] a, logic [15:0] p, bit mix);
    request_t r;
    for (int i = 0; i < len; i++) begin
      if (mix && $urandom_range(0, 39) == 0) add_random_rule();
      r = rand_request(CMD_FRAME);
      r.last = (i == len - 1);
      case (i)
        12: r.fbyte = etype[15:8];
        13: r.fbyte = etype[7:0];
        23: r.fbyte = proto;
        30: r.fbyte = a[31:24];
        31: r.fbyte = a[23:16];
        32: r.fbyte = a[15:8];
        33: r.fbyte = a[7:0];
        36: r.fbyte = p[15:8];
        37: r.fbyte = p[7:0];
        default: ;
      endcase
      request_q.push_back(r);
    end
    planned_results++;
  endtask

  task automatic add_random_frame();
    int len;
    logic [15:0] etype;
    logic [7:0] proto;
    int pick;
    pick = $urandom_range(0, 9);
    etype = (pick == 0) ? 16'($urandom) : ((pick == 1) ? 16'h0008 : ETHERTYPE_IPV4);
    pick = $urandom_range(0, 9);
    proto = (pick < 4) ? PROTO_TCP : ((pick < 8) ? PROTO_UDP : 8'($urandom));
    pick = $urandom_range(0, 9);
    if (pick == 0) len = $urandom_range(1, 33);
    else if (pick < 3) len = $urandom_range(34, 56);
    else if (pick == 3) len = $urandom_range(60, 72);
    else len = (proto == PROTO_UDP) ? $urandom_range(42, 48) : $urandom_range(54, 58);
    add_frame(len, etype, proto, addr_pool[$urandom_range(0, 11)],
              port_pool[$urandom_range(0, 3)], 1'b1);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Sender: draws a gap per request, with bursts that have none.
  int send_gap = 0;
  bit send_burst = 1'b0;
  request_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        filter_step(cur);
        accepted++;
        if (accepted == 300) hold_start = 1'b1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur = request_q.pop_front();
          cmd_i <= cur.cmd;
          frame_byte_i <= cur.fbyte;
          frame_last_i <= cur.last;
          rule_address_i <= cur.addr;
          rule_port_i <= cur.port;
          rule_value_i <= cur.value;
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls per result plus one long hold-off.
  int recv_wait = 0;
  int long_left = 0;
  bit long_done = 1'b0;
  bit recv_burst = 1'b0;
  outcome_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (result_kind_o !== want.kind) report_mismatch("result_kind", result_kind_o, want.kind);
          if (drop_o !== want.drop) report_mismatch("drop", drop_o, want.drop);
          if (verdict_cause_o !== want.cause)
            report_mismatch("verdict_cause", verdict_cause_o, want.cause);
          if (table_status_o !== want.status)
            report_mismatch("table_status", table_status_o, want.status);
        end
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 16);
      end
      if (hold_start && !long_done) begin
        long_done = 1'b1;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall_i <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ipv4_dest_block_filter test failed");
      $finish;
    end
  end

  initial begin
    addr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0102_0304, 32'hAC10_0A0B,
                  32'h5555_AAAA, 32'hAAAA_5555, 32'h0A00_0002, 32'hDEAD_BEEF};
    port_pool = '{16'h0000, 16'hFFFF, 16'd80, 16'h8001};

    // Directed part: every command, each cause, updates and misses.
    add_rule(CMD_SET_ADDR, 32'h0000_0000, 16'd0, 32'd1);
    add_rule(CMD_SET_ADDR, 32'hFFFF_FFFF, 16'd0, 32'd2);
    add_rule(CMD_DEL_ADDR, 32'h0A00_0001, 16'd0, 32'd1);
    add_rule(CMD_SET_PAIR, 32'hC0A8_0101, 16'hFFFF, 32'd1);
    add_rule(CMD_DEL_PAIR, 32'hC0A8_0101, 16'd7, 32'd1);
    add_frame(1, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 16'd0, 1'b0);
    add_frame(13, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 16'd0, 1'b0);
    add_frame(60, 16'h0008, PROTO_TCP, 32'h0, 16'd0, 1'b0);
    add_frame(33, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 16'd0, 1'b0);
    add_frame(34, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 16'd0, 1'b0);
    add_frame(54, ETHERTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 16'd0, 1'b0);
    add_frame(40, ETHERTYPE_IPV4, 8'd1, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_frame(53, ETHERTYPE_IPV4, PROTO_TCP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_frame(54, ETHERTYPE_IPV4, PROTO_TCP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_frame(41, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_frame(72, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_rule(CMD_SET_PAIR, 32'hC0A8_0101, 16'hFFFF, 32'hFFFF_FFFF);
    add_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0101, 16'hFFFF, 1'b0);
    add_rule(CMD_DEL_PAIR, 32'hC0A8_0101, 16'hFFFF, 32'd0);
    add_rule(CMD_DEL_ADDR, 32'h0000_0000, 16'd0, 32'd0);
    request_q.push_back(rand_request(3'(CMD_DEL_PAIR) + 3'd3));

    // Random part: mostly well-formed frames, rules drawn from small pools.
    while (request_q.size() < N_REQUESTS || planned_results < MIN_RESULTS) begin
      if ($urandom_range(0, 2) == 0) add_random_rule();
      else add_random_frame();
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || in_valid_i || outcome_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("ipv4_dest_block_filter test passed");
    end else begin
      $display("ipv4_dest_block_filter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/ipdbf_pkg.sv
design/ipdbf_ram.sv
design/ipdbf_parser.sv
design/ipv4_dest_block_filter.sv
bench/testbench.sv
